FILE: rtl/gfau_pkg.sv
// ----------------------------------------------------------------------------
// GF(2^m) arithmetic unit - shared package
// Types, codes and sizing constants used by the field arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

   // Width of an element port and of the reduction polynomial register.
   localparam int ELEM_W      = 64;
   // Largest field degree supported.
   localparam int MAX_DEGREE  = 64;
   localparam int DEG_W       = 7;
   localparam int DEG_MIN     = 2;

   // The multiplier consumes this many bits of its second operand per cycle.
   localparam int MUL_DIGIT   = 4;
   localparam int MUL_CYCLES  = (MAX_DEGREE + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int MUL_CNT_W   = (MUL_CYCLES > 1) ? $clog2(MUL_CYCLES) : 1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_DEGREE   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_REDUCTION_POLY = CSR_INDEX_W'(1);

   localparam logic [DEG_W-1:0]  DEGREE_RESET = DEG_W'(64);
   localparam logic [ELEM_W-1:0] POLY_RESET   = ELEM_W'(27);

   typedef logic [ELEM_W-1:0] elem_type;

   typedef enum logic [2:0] {
      CMD_ADD     = 3'd0,
      CMD_MULT    = 3'd1,
      CMD_SQUARE  = 3'd2,
      CMD_DIVIDE  = 3'd3,
      CMD_INVERSE = 3'd4,
      CMD_POWER   = 3'd5,
      CMD_SQRT    = 3'd6,
      CMD_TRACE   = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POW_CHECK,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_ITER,
      ST_LAST_MUL
   } seq_state_type;

   // Field description derived from the configuration registers.
   typedef struct packed {
      logic [DEG_W-1:0] degm1;   // effective degree minus one
      elem_type         mask;    // ones in the low m bits
      elem_type         topsel;  // one-hot at bit m-1
      elem_type         poly;    // reduction polynomial, masked to m bits
   } field_cfg_type;

endpackage

FILE: rtl/gfau_cfg.sv
// ----------------------------------------------------------------------------
// GF(2^m) arithmetic unit - configuration registers
// Holds the field degree and reduction polynomial and derives the element
// mask, top-bit select and masked polynomial used by the datapath.
// ----------------------------------------------------------------------------
module gfau_cfg
   import gfau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ELEM_W-1:0]      csr_wdata,
   output field_cfg_type          field_cfg
);

   logic [DEG_W-1:0]  degree_ff, degree_in;
   logic [ELEM_W-1:0] poly_ff, poly_in;
   logic [DEG_W-1:0]  deg_eff;
   elem_type          mask;
   elem_type          topsel;

   always_comb begin
      degree_in = degree_ff;
      poly_in   = poly_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIELD_DEGREE:   degree_in = csr_wdata[DEG_W-1:0];
            CSR_REDUCTION_POLY: poly_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
         poly_ff   <= POLY_RESET;
      end else begin
         degree_ff <= degree_in;
         poly_ff   <= poly_in;
      end
   end

   // Degrees outside the supported range are clamped to its ends.
   always_comb begin
      if (degree_ff < DEG_W'(DEG_MIN)) begin
         deg_eff = DEG_W'(DEG_MIN);
      end else if (degree_ff > DEG_W'(MAX_DEGREE)) begin
         deg_eff = DEG_W'(MAX_DEGREE);
      end else begin
         deg_eff = degree_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < ELEM_W; i++) begin
         mask[i]   = (i < int'(deg_eff));
         topsel[i] = (i == int'(deg_eff) - 1);
      end
   end

   assign field_cfg.degm1  = deg_eff - DEG_W'(1);
   assign field_cfg.mask   = mask;
   assign field_cfg.topsel = topsel;
   assign field_cfg.poly   = poly_ff & mask;

`ifndef NO_ASSERTIONS
   a_cfg_shape: assert property (@(posedge clock) disable iff (reset)
      $onehot(field_cfg.topsel) && ((field_cfg.mask & field_cfg.topsel) != '0)
      && ((field_cfg.poly & ~field_cfg.mask) == '0))
      else $error("field description is inconsistent");
`endif

endmodule

FILE: rtl/gfau_mul.sv
// ----------------------------------------------------------------------------
// GF(2^m) arithmetic unit - shared field multiplier
// Digit-serial shift-and-add multiplier with reduction after every shift.
// Scans the second operand from its least significant bit, a few bits a cycle.
// ----------------------------------------------------------------------------
module gfau_mul
   import gfau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  field_cfg_type field_cfg,
   input  logic          start,
   input  elem_type      op_a,
   input  elem_type      op_b,
   output logic          done,
   output elem_type      product
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   elem_type             a_ff, a_in;
   elem_type             b_ff, b_in;
   elem_type             p_ff, p_in;
   elem_type             a_step;
   elem_type             p_step;

   // One digit of the second operand per cycle.
   always_comb begin
      logic top;
      a_step = a_ff;
      p_step = p_ff;
      for (int j = 0; j < MUL_DIGIT; j++) begin
         if (b_ff[j]) begin
            p_step = p_step ^ a_step;
         end
         top    = |(a_step & field_cfg.topsel);
         a_step = ((a_step << 1) & field_cfg.mask) ^ (top ? field_cfg.poly : '0);
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = MUL_CNT_W'(MUL_CYCLES - 1);
         a_in   = op_a;
         b_in   = op_b;
         p_in   = '0;
      end else if (run_ff) begin
         a_in   = a_step;
         b_in   = b_ff >> MUL_DIGIT;
         p_in   = p_step;
         cnt_in = cnt_ff - MUL_CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

`ifndef NO_ASSERTIONS
   a_mul_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("multiplier started while still running");

   a_mul_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(run_ff))
      else $error("multiplier done without a preceding run");
`endif

endmodule

FILE: rtl/gf2m_arith_unit_core.sv
// ----------------------------------------------------------------------------
// GF(2^m) arithmetic unit - top level
// Polynomial-basis field arithmetic: add, multiply, square, divide, inverse,
// power, square root and trace; all but add use one shared field multiplier.
//
//   channel   ports                                  transfer when
//   request   start, busy, req_cmd, req_operand_a/b  start high, busy low
//   response  rsp_valid, rsp_result                  rsp_valid high
//   config    csr_we, csr_index, csr_wdata           csr_we high
//
// Every operation but add runs on the shared multiplier, and a request is
// taken only while busy is low. Add answers in the cycle after the transfer;
// multiply and square take one multiplication; power one squaring per
// exponent bit up to its top set bit plus one multiplication per set bit
// (divide adds one more); square root and trace take m-1 squarings.
// Reset selects m = 64 with polynomial x^64+x^4+x^3+x+1 and idles the block.
// Each result is strobed for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module gf2m_arith_unit_core
   import gfau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_cmd,
   input  logic [ELEM_W-1:0]      req_operand_a,
   input  logic [ELEM_W-1:0]      req_operand_b,
   output logic                   rsp_valid,
   output logic [ELEM_W-1:0]      rsp_result,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ELEM_W-1:0]      csr_wdata
);

   field_cfg_type     field_cfg;
   seq_state_type     state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   elem_type          opa_ff, opa_in;
   elem_type          x_ff, x_in;
   elem_type          r_ff, r_in;
   elem_type          e_ff, e_in;
   logic [DEG_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   elem_type          rsp_result_ff, rsp_result_in;

   logic              accept;
   cmd_type           req_cmd_t;
   elem_type          a_m;
   elem_type          b_m;
   elem_type          iter_val;
   logic              mul_start;
   elem_type          mul_a;
   elem_type          mul_b;
   logic              mul_done;
   elem_type          mul_product;

   gfau_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .field_cfg (field_cfg)
   );

   gfau_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .field_cfg (field_cfg),
      .start     (mul_start),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .done      (mul_done),
      .product   (mul_product)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign req_cmd_t = cmd_type'(req_cmd);
   assign a_m       = req_operand_a & field_cfg.mask;
   assign b_m       = req_operand_b & field_cfg.mask;
   // Trace adds the original operand back after every squaring.
   assign iter_val  = mul_product ^ ((cmd_ff == CMD_TRACE) ? opa_ff : '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd_t)
                  CMD_ADD:                             state_in = ST_IDLE;
                  CMD_MULT, CMD_SQUARE:                state_in = ST_LAST_MUL;
                  CMD_DIVIDE, CMD_INVERSE, CMD_POWER:  state_in = ST_POW_CHECK;
                  CMD_SQRT, CMD_TRACE:                 state_in = ST_ITER;
                  default:                             state_in = ST_IDLE;
               endcase
            end
         end
         ST_POW_CHECK: begin
            if (e_ff == '0) begin
               state_in = (cmd_ff == CMD_DIVIDE) ? ST_LAST_MUL : ST_IDLE;
            end else if (e_ff[0]) begin
               state_in = ST_POW_MUL;
            end else begin
               state_in = ST_POW_SQR;
            end
         end
         ST_POW_MUL: begin
            if (mul_done) state_in = ST_POW_SQR;
         end
         ST_POW_SQR: begin
            if (mul_done) state_in = ST_POW_CHECK;
         end
         ST_ITER: begin
            if (mul_done && cnt_ff == DEG_W'(1)) state_in = ST_IDLE;
         end
         ST_LAST_MUL: begin
            if (mul_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Multiplier requests, working registers and the response.
   always_comb begin
      cmd_in        = cmd_ff;
      opa_in        = opa_ff;
      x_in          = x_ff;
      r_in          = r_ff;
      e_in          = e_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      mul_start     = 1'b0;
      mul_a         = r_ff;
      mul_b         = x_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd_t;
               opa_in = a_m;
               case (req_cmd_t)
                  CMD_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = a_m ^ b_m;
                  end
                  CMD_MULT: begin
                     mul_start = 1'b1;
                     mul_a     = a_m;
                     mul_b     = b_m;
                  end
                  CMD_SQUARE: begin
                     mul_start = 1'b1;
                     mul_a     = a_m;
                     mul_b     = a_m;
                  end
                  CMD_DIVIDE: begin
                     // Invert the divisor first, then multiply it in.
                     x_in = b_m;
                     e_in = field_cfg.mask - ELEM_W'(1);
                     r_in = ELEM_W'(1);
                  end
                  CMD_INVERSE: begin
                     x_in = a_m;
                     e_in = field_cfg.mask - ELEM_W'(1);
                     r_in = ELEM_W'(1);
                  end
                  CMD_POWER: begin
                     x_in = a_m;
                     e_in = req_operand_b;
                     r_in = ELEM_W'(1);
                  end
                  CMD_SQRT, CMD_TRACE: begin
                     r_in      = a_m;
                     cnt_in    = field_cfg.degm1;
                     mul_start = 1'b1;
                     mul_a     = a_m;
                     mul_b     = a_m;
                  end
                  default: ;
               endcase
            end
         end
         ST_POW_CHECK: begin
            if (e_ff == '0) begin
               if (cmd_ff == CMD_DIVIDE) begin
                  mul_start = 1'b1;
                  mul_a     = opa_ff;
                  mul_b     = r_ff;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = r_ff;
               end
            end else if (e_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = r_ff;
               mul_b     = x_ff;
            end else begin
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = x_ff;
            end
         end
         ST_POW_MUL: begin
            if (mul_done) begin
               r_in      = mul_product;
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = x_ff;
            end
         end
         ST_POW_SQR: begin
            if (mul_done) begin
               x_in = mul_product;
               e_in = e_ff >> 1;
            end
         end
         ST_ITER: begin
            if (mul_done) begin
               r_in   = iter_val;
               cnt_in = cnt_ff - DEG_W'(1);
               if (cnt_ff == DEG_W'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = iter_val;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = iter_val;
                  mul_b     = iter_val;
               end
            end
         end
         ST_LAST_MUL: begin
            if (mul_done) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = mul_product;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      opa_ff        <= opa_in;
      x_ff          <= x_in;
      r_ff          <= r_in;
      e_ff          <= e_in;
      cnt_ff        <= cnt_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef NO_ASSERTIONS
   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("sequence finished without a result");

   a_long_op_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd != CMD_ADD) |=> busy)
      else $error("multi-cycle operation did not hold the block busy");

   a_add_direct: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_ADD) |=> (rsp_valid && !busy))
      else $error("add did not answer in the following cycle");
`endif

endmodule
